// ===== rtl/lav_pkg.sv =====
package lav_pkg;

   // Field widths
   localparam int COORD_W = 32;
   localparam int UNIT_W  = 18;
   localparam int FRAC_W  = 16;

   // Normalizer internals
   localparam int MAG_W  = 31;
   localparam int SUM_W  = 64;
   localparam int ROOT_W = 32;
   localparam int QUO_W  = 17;

   // Product and sum widths of the back end
   localparam int UPROD_W = 2 * UNIT_W;
   localparam int UDIFF_W = UPROD_W + 1;
   localparam int DPROD_W = UNIT_W + COORD_W;
   localparam int DSUM_W  = DPROD_W + 2;
   localparam int DRND_W  = DSUM_W - FRAC_W + 1;

   localparam logic [UNIT_W-1:0] ONE_Q16 = UNIT_W'(65536);

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix unit: signed Q16.16 coordinates, Q1.16 unit columns.
// Request channel (req_valid / req_stall) carries eye, target and up.
// Response channel (rsp_valid / rsp_stall) carries the right, upward and
// back columns (18-bit) and the three saturated translation terms (32-bit).
// A transfer happens on a rising edge with valid high and stall low.
// A request passes the input register, two vector normalizers of 56
// stages each (32 square root stages and 17 divide stages), cross
// product, rounding and dot product stages and the output register.
// One request is taken every cycle while no response is held.
// Zero-length vectors normalize to zero.
// When the response is held by rsp_stall the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
module look_at_view_matrix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [lav_pkg::COORD_W-1:0] req_eye_x,
   input  logic signed [lav_pkg::COORD_W-1:0] req_eye_y,
   input  logic signed [lav_pkg::COORD_W-1:0] req_eye_z,
   input  logic signed [lav_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [lav_pkg::COORD_W-1:0] req_target_y,
   input  logic signed [lav_pkg::COORD_W-1:0] req_target_z,
   input  logic signed [lav_pkg::COORD_W-1:0] req_up_x,
   input  logic signed [lav_pkg::COORD_W-1:0] req_up_y,
   input  logic signed [lav_pkg::COORD_W-1:0] req_up_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_right_x,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_right_y,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_right_z,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_upward_x,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_upward_y,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_upward_z,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_back_x,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_back_y,
   output logic signed [lav_pkg::UNIT_W-1:0]  rsp_back_z,
   output logic signed [lav_pkg::COORD_W-1:0] rsp_shift_right,
   output logic signed [lav_pkg::COORD_W-1:0] rsp_shift_up,
   output logic signed [lav_pkg::COORD_W-1:0] rsp_shift_forward
);
   import lav_pkg::*;

   localparam int DIR_W   = COORD_W + 1;
   localparam int XPROD_W = UNIT_W + COORD_W;
   localparam int XDIFF_W = XPROD_W + 1;
   localparam int VEC_W   = 3 * COORD_W;
   localparam int UVEC_W  = 3 * UNIT_W;
   localparam int S1_W    = 2 * VEC_W;
   localparam int S2_W    = VEC_W + UVEC_W;
   localparam int DL_W    = 3 * UVEC_W;
   localparam int DOT_N   = 3;
   localparam int NEG_W   = DRND_W + 1;

   logic en;

   // Freeze everything while a response is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Input register: eye, up and target minus eye
   logic                      v_in_ff;
   logic signed [COORD_W-1:0] eye_in_ff [3];
   logic signed [COORD_W-1:0] up_in_ff  [3];
   logic signed [DIR_W-1:0]   dir_in_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v_in_ff <= 1'b0;
      else if (en) v_in_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eye_in_ff <= '{req_eye_x, req_eye_y, req_eye_z};
         up_in_ff  <= '{req_up_x, req_up_y, req_up_z};
         dir_in_ff[0] <= DIR_W'(req_target_x) - DIR_W'(req_eye_x);
         dir_in_ff[1] <= DIR_W'(req_target_y) - DIR_W'(req_eye_y);
         dir_in_ff[2] <= DIR_W'(req_target_z) - DIR_W'(req_eye_z);
      end
   end

   // Forward vector
   logic                     n1_valid;
   logic signed [UNIT_W-1:0] fwd [3];
   logic [S1_W-1:0]          n1_side;

   lav_norm #(.W(DIR_W), .SIDE_W(S1_W)) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_in_ff),
      .in_vec   (dir_in_ff),
      .in_side  ({eye_in_ff[0], eye_in_ff[1], eye_in_ff[2],
                  up_in_ff[0], up_in_ff[1], up_in_ff[2]}),
      .out_valid(n1_valid),
      .out_vec  (fwd),
      .out_side (n1_side)
   );

   logic signed [COORD_W-1:0] eye_n1 [3];
   logic signed [COORD_W-1:0] up_n1  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_n1[i] = n1_side[S1_W-1-COORD_W*i -: COORD_W];
         up_n1[i]  = n1_side[VEC_W-1-COORD_W*i -: COORD_W];
      end
   end

   // Cross of forward and up: products, then differences
   logic                      v_x1_ff, v_x2_ff;
   logic signed [XPROD_W-1:0] px_ff  [6];
   logic signed [COORD_W-1:0] eye_x1_ff [3];
   logic signed [UNIT_W-1:0]  fwd_x1_ff [3];
   logic signed [XDIFF_W-1:0] cr_x2_ff  [3];
   logic signed [COORD_W-1:0] eye_x2_ff [3];
   logic signed [UNIT_W-1:0]  fwd_x2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_x1_ff <= 1'b0;
         v_x2_ff <= 1'b0;
      end else if (en) begin
         v_x1_ff <= n1_valid;
         v_x2_ff <= v_x1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0] <= XPROD_W'(fwd[1]) * XPROD_W'(up_n1[2]);
         px_ff[1] <= XPROD_W'(fwd[2]) * XPROD_W'(up_n1[1]);
         px_ff[2] <= XPROD_W'(fwd[2]) * XPROD_W'(up_n1[0]);
         px_ff[3] <= XPROD_W'(fwd[0]) * XPROD_W'(up_n1[2]);
         px_ff[4] <= XPROD_W'(fwd[0]) * XPROD_W'(up_n1[1]);
         px_ff[5] <= XPROD_W'(fwd[1]) * XPROD_W'(up_n1[0]);
         eye_x1_ff <= eye_n1;
         fwd_x1_ff <= fwd;
         for (int i = 0; i < 3; i++) begin
            cr_x2_ff[i] <= XDIFF_W'(px_ff[2*i]) - XDIFF_W'(px_ff[2*i+1]);
         end
         eye_x2_ff <= eye_x1_ff;
         fwd_x2_ff <= fwd_x1_ff;
      end
   end

   // Right vector
   logic                     n2_valid;
   logic signed [UNIT_W-1:0] rgt [3];
   logic [S2_W-1:0]          n2_side;

   lav_norm #(.W(XDIFF_W), .SIDE_W(S2_W)) u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_x2_ff),
      .in_vec   (cr_x2_ff),
      .in_side  ({eye_x2_ff[0], eye_x2_ff[1], eye_x2_ff[2],
                  fwd_x2_ff[0], fwd_x2_ff[1], fwd_x2_ff[2]}),
      .out_valid(n2_valid),
      .out_vec  (rgt),
      .out_side (n2_side)
   );

   logic signed [COORD_W-1:0] eye_n2 [3];
   logic signed [UNIT_W-1:0]  fwd_n2 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_n2[i] = n2_side[S2_W-1-COORD_W*i -: COORD_W];
         fwd_n2[i] = n2_side[UVEC_W-1-UNIT_W*i -: UNIT_W];
      end
   end

   // Upward vector: right cross forward, round and clamp
   logic                      v_u1_ff, v_u2_ff, v_u3_ff;
   logic signed [UPROD_W-1:0] pu_ff [6];
   logic signed [UDIFF_W-1:0] uc_ff [3];
   logic signed [UNIT_W-1:0]  upw_ff [3];
   logic signed [UNIT_W-1:0]  rgt_u_ff [3][3];
   logic signed [UNIT_W-1:0]  fwd_u_ff [3][3];
   logic signed [COORD_W-1:0] eye_u_ff [3][3];
   logic [UDIFF_W-1:0]        umag [3];
   logic [UDIFF_W-1:0]        urnd [3];
   logic [UNIT_W-1:0]         uclp [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_u1_ff <= 1'b0;
         v_u2_ff <= 1'b0;
         v_u3_ff <= 1'b0;
      end else if (en) begin
         v_u1_ff <= n2_valid;
         v_u2_ff <= v_u1_ff;
         v_u3_ff <= v_u2_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         umag[i] = uc_ff[i][UDIFF_W-1] ? UDIFF_W'(-uc_ff[i]) : UDIFF_W'(uc_ff[i]);
         urnd[i] = (umag[i] + UDIFF_W'(32768)) >> FRAC_W;
         if (urnd[i] > UDIFF_W'(ONE_Q16)) uclp[i] = ONE_Q16;
         else uclp[i] = UNIT_W'(urnd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff[0] <= UPROD_W'(rgt[1]) * UPROD_W'(fwd_n2[2]);
         pu_ff[1] <= UPROD_W'(rgt[2]) * UPROD_W'(fwd_n2[1]);
         pu_ff[2] <= UPROD_W'(rgt[2]) * UPROD_W'(fwd_n2[0]);
         pu_ff[3] <= UPROD_W'(rgt[0]) * UPROD_W'(fwd_n2[2]);
         pu_ff[4] <= UPROD_W'(rgt[0]) * UPROD_W'(fwd_n2[1]);
         pu_ff[5] <= UPROD_W'(rgt[1]) * UPROD_W'(fwd_n2[0]);
         for (int i = 0; i < 3; i++) begin
            uc_ff[i]  <= UDIFF_W'(pu_ff[2*i]) - UDIFF_W'(pu_ff[2*i+1]);
            upw_ff[i] <= uc_ff[i][UDIFF_W-1] ? -uclp[i] : uclp[i];
         end
         rgt_u_ff[0] <= rgt;
         fwd_u_ff[0] <= fwd_n2;
         eye_u_ff[0] <= eye_n2;
         for (int s = 1; s < 3; s++) begin
            rgt_u_ff[s] <= rgt_u_ff[s-1];
            fwd_u_ff[s] <= fwd_u_ff[s-1];
            eye_u_ff[s] <= eye_u_ff[s-1];
         end
      end
   end

   // Dot products with the eye
   logic signed [DRND_W-1:0] dot_r, dot_u, dot_f;

   lav_dot u_dot_right (
      .clock(clock), .en(en), .a(rgt_u_ff[2]), .e(eye_u_ff[2]), .dot(dot_r)
   );

   lav_dot u_dot_up (
      .clock(clock), .en(en), .a(upw_ff), .e(eye_u_ff[2]), .dot(dot_u)
   );

   lav_dot u_dot_fwd (
      .clock(clock), .en(en), .a(fwd_u_ff[2]), .e(eye_u_ff[2]), .dot(dot_f)
   );

   // Hold the columns until the dot products are ready
   logic            v_d_ff  [DOT_N];
   logic [DL_W-1:0] col_d_ff [DOT_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DOT_N; s++) v_d_ff[s] <= 1'b0;
      end else if (en) begin
         v_d_ff[0] <= v_u3_ff;
         for (int s = 1; s < DOT_N; s++) v_d_ff[s] <= v_d_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_d_ff[0] <= {rgt_u_ff[2][0], rgt_u_ff[2][1], rgt_u_ff[2][2],
                         upw_ff[0], upw_ff[1], upw_ff[2],
                         fwd_u_ff[2][0], fwd_u_ff[2][1], fwd_u_ff[2][2]};
         for (int s = 1; s < DOT_N; s++) col_d_ff[s] <= col_d_ff[s-1];
      end
   end

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [NEG_W-1:0] v);
      logic signed [NEG_W-1:0] hi;
      logic signed [NEG_W-1:0] lo;
      hi = NEG_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - NEG_W'(1);
      if (v > hi) return COORD_W'(hi);
      else if (v < lo) return COORD_W'(lo);
      else return COORD_W'(v);
   endfunction

   // Output register
   logic                      rsp_valid_ff;
   logic signed [UNIT_W-1:0]  right_ff [3];
   logic signed [UNIT_W-1:0]  upward_ff [3];
   logic signed [UNIT_W-1:0]  back_ff [3];
   logic signed [COORD_W-1:0] sh_right_ff, sh_up_ff, sh_fwd_ff;
   logic [DL_W-1:0]           col;

   assign col = col_d_ff[DOT_N-1];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= v_d_ff[DOT_N-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            right_ff[i]  <= col[DL_W-1-UNIT_W*i -: UNIT_W];
            upward_ff[i] <= col[2*UVEC_W-1-UNIT_W*i -: UNIT_W];
            back_ff[i]   <= -$signed(col[UVEC_W-1-UNIT_W*i -: UNIT_W]);
         end
         sh_right_ff <= sat32(-NEG_W'(dot_r));
         sh_up_ff    <= sat32(-NEG_W'(dot_u));
         sh_fwd_ff   <= sat32(NEG_W'(dot_f));
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_x       = right_ff[0];
   assign rsp_right_y       = right_ff[1];
   assign rsp_right_z       = right_ff[2];
   assign rsp_upward_x      = upward_ff[0];
   assign rsp_upward_y      = upward_ff[1];
   assign rsp_upward_z      = upward_ff[2];
   assign rsp_back_x        = back_ff[0];
   assign rsp_back_y        = back_ff[1];
   assign rsp_back_z        = back_ff[2];
   assign rsp_shift_right   = sh_right_ff;
   assign rsp_shift_up      = sh_up_ff;
   assign rsp_shift_forward = sh_fwd_ff;

   // Unit columns stay within one
   a_right_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_x <= 18'sd65536) && (rsp_right_x >= -18'sd65536))
      else $error("right_x out of unit range");

   a_upward_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_upward_y <= 18'sd65536) && (rsp_upward_y >= -18'sd65536))
      else $error("upward_y out of unit range");

   a_back_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_back_z <= 18'sd65536) && (rsp_back_z >= -18'sd65536))
      else $error("back_z out of unit range");

   // A degenerate forward vector collapses the whole matrix
   a_zero_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_back_x == '0) && (rsp_back_y == '0) && (rsp_back_z == '0)
      |-> (rsp_right_x == '0) && (rsp_right_y == '0) && (rsp_right_z == '0)
          && (rsp_shift_forward == '0) && (rsp_shift_right == '0))
      else $error("zero forward gave nonzero terms");

endmodule

// ===== rtl/lav_norm.sv =====
module lav_norm #(
   parameter int W      = 33,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [W-1:0]                in_vec [3],
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [lav_pkg::UNIT_W-1:0]  out_vec [3],
   output logic [SIDE_W-1:0]                  out_side
);
   import lav_pkg::*;

   localparam int KW     = $clog2(W + 1);
   localparam int SQRT_N = ROOT_W;
   localparam int DIV_N  = QUO_W;
   localparam int LAT    = 5 + SQRT_N + 1 + DIV_N + 1;
   localparam int REM_W  = ROOT_W + 4;
   localparam int NUM_W  = MAG_W + FRAC_W + 1;

   // Valid and side data travel alongside the arithmetic
   logic              valid_ff [LAT];
   logic [SIDE_W-1:0] side_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < LAT; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // Take magnitudes, keep signs
   logic [W-1:0] mag_a_ff [3];
   logic         neg_a_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg_a_ff[i] <= in_vec[i][W-1];
            mag_a_ff[i] <= in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
         end
      end
   end

   // Find the scale shift from the highest set bit of all magnitudes
   logic [W-1:0]  or_all;
   logic [KW-1:0] bitlen;
   logic [KW-1:0] k_in;
   logic [KW-1:0] k_b_ff;
   logic [W-1:0]  mag_b_ff [3];
   logic          neg_b_ff [3];

   always_comb begin
      or_all = mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2];
      bitlen = '0;
      for (int j = 0; j < W; j++) begin
         if (or_all[j]) bitlen = KW'(j + 1);
      end
      if (bitlen > KW'(MAG_W)) k_in = bitlen - KW'(MAG_W);
      else k_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_b_ff   <= k_in;
         mag_b_ff <= mag_a_ff;
         neg_b_ff <= neg_a_ff;
      end
   end

   // Scale down
   logic [MAG_W-1:0] m_c_ff   [3];
   logic             neg_c_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) m_c_ff[i] <= MAG_W'(mag_b_ff[i] >> k_b_ff);
         neg_c_ff <= neg_b_ff;
      end
   end

   // Square
   logic [2*MAG_W-1:0] sq_d_ff  [3];
   logic [MAG_W-1:0]   m_d_ff   [3];
   logic               neg_d_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_d_ff[i] <= (2*MAG_W)'(m_c_ff[i]) * (2*MAG_W)'(m_c_ff[i]);
         end
         m_d_ff   <= m_c_ff;
         neg_d_ff <= neg_c_ff;
      end
   end

   // Sum of squares
   logic [SUM_W-1:0] sum_e_ff;
   logic [MAG_W-1:0] m_e_ff   [3];
   logic             neg_e_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         sum_e_ff <= SUM_W'(sq_d_ff[0]) + SUM_W'(sq_d_ff[1]) + SUM_W'(sq_d_ff[2]);
         m_e_ff   <= m_d_ff;
         neg_e_ff <= neg_d_ff;
      end
   end

   // Square root, one result bit per stage
   logic [SUM_W-1:0]  rad_ff  [SQRT_N];
   logic [REM_W-1:0]  srem_ff [SQRT_N];
   logic [ROOT_W-1:0] root_ff [SQRT_N];
   logic [MAG_W-1:0]  sm_ff   [SQRT_N][3];
   logic              sneg_ff [SQRT_N][3];

   for (genvar s = 0; s < SQRT_N; s++) begin : g_sqrt
      logic [SUM_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [MAG_W-1:0]  m_prev   [3];
      logic              neg_prev [3];
      logic [REM_W-1:0]  rem_t;
      logic [REM_W-1:0]  trial;

      if (s == 0) begin : g_first
         assign rad_prev  = sum_e_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign m_prev    = m_e_ff;
         assign neg_prev  = neg_e_ff;
      end else begin : g_next
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = srem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign m_prev    = sm_ff[s-1];
         assign neg_prev  = sneg_ff[s-1];
      end

      assign rem_t = {rem_prev[REM_W-3:0], rad_prev[SUM_W-1 -: 2]};
      assign trial = REM_W'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_prev << 2;
            sm_ff[s]   <= m_prev;
            sneg_ff[s] <= neg_prev;
            if (rem_t >= trial) begin
               srem_ff[s] <= rem_t - trial;
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff[s] <= rem_t;
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // Form rounded numerators
   logic [NUM_W-1:0]  num_n_ff [3];
   logic [ROOT_W-1:0] len_n_ff;
   logic              zero_n_ff;
   logic              neg_n_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num_n_ff[i] <= NUM_W'({sm_ff[SQRT_N-1][i], FRAC_W'(0)})
                           + NUM_W'(root_ff[SQRT_N-1] >> 1);
         end
         len_n_ff  <= root_ff[SQRT_N-1];
         zero_n_ff <= (root_ff[SQRT_N-1] == '0);
         neg_n_ff  <= sneg_ff[SQRT_N-1];
      end
   end

   // Divide by the length, one quotient bit per stage
   logic [ROOT_W-1:0] drem_ff  [DIV_N][3];
   logic [QUO_W-1:0]  quo_ff   [DIV_N][3];
   logic [QUO_W-1:0]  dlow_ff  [DIV_N][3];
   logic [ROOT_W-1:0] dlen_ff  [DIV_N];
   logic              dzero_ff [DIV_N];
   logic              dneg_ff  [DIV_N][3];

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [ROOT_W-1:0] rem_prev  [3];
      logic [QUO_W-1:0]  q_prev    [3];
      logic [QUO_W-1:0]  low_prev  [3];
      logic [ROOT_W-1:0] len_prev;
      logic              zero_prev;
      logic              neg_prev  [3];

      if (j == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = ROOT_W'(num_n_ff[i][NUM_W-1:QUO_W]);
            assign low_prev[i] = num_n_ff[i][QUO_W-1:0];
            assign q_prev[i]   = '0;
         end
         assign len_prev  = len_n_ff;
         assign zero_prev = zero_n_ff;
         assign neg_prev  = neg_n_ff;
      end else begin : g_next
         assign rem_prev  = drem_ff[j-1];
         assign low_prev  = dlow_ff[j-1];
         assign q_prev    = quo_ff[j-1];
         assign len_prev  = dlen_ff[j-1];
         assign zero_prev = dzero_ff[j-1];
         assign neg_prev  = dneg_ff[j-1];
      end

      always_ff @(posedge clock) begin
         logic [ROOT_W:0] t;
         if (en) begin
            dlen_ff[j]  <= len_prev;
            dzero_ff[j] <= zero_prev;
            dneg_ff[j]  <= neg_prev;
            for (int i = 0; i < 3; i++) begin
               t = {rem_prev[i], low_prev[i][QUO_W-1]};
               dlow_ff[j][i] <= low_prev[i] << 1;
               if (t >= {1'b0, len_prev}) begin
                  drem_ff[j][i] <= ROOT_W'(t - {1'b0, len_prev});
                  quo_ff[j][i]  <= {q_prev[i][QUO_W-2:0], 1'b1};
               end else begin
                  drem_ff[j][i] <= ROOT_W'(t);
                  quo_ff[j][i]  <= {q_prev[i][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Apply signs; zero length gives zero
   logic signed [UNIT_W-1:0] out_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dzero_ff[DIV_N-1]) out_ff[i] <= '0;
            else if (dneg_ff[DIV_N-1][i]) out_ff[i] <= -UNIT_W'(quo_ff[DIV_N-1][i]);
            else out_ff[i] <= UNIT_W'(quo_ff[DIV_N-1][i]);
         end
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];
   assign out_vec   = out_ff;

endmodule

// ===== rtl/lav_dot.sv =====
module lav_dot (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [lav_pkg::UNIT_W-1:0]  a [3],
   input  logic signed [lav_pkg::COORD_W-1:0] e [3],
   output logic signed [lav_pkg::DRND_W-1:0]  dot
);
   import lav_pkg::*;

   logic signed [DPROD_W-1:0] prod_ff [3];
   logic signed [DSUM_W-1:0]  sum_ff;
   logic signed [DRND_W-1:0]  dot_ff;
   logic [DSUM_W-1:0]         mag;
   logic [DSUM_W-1:0]         rnd;

   // Multiply per component
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= DPROD_W'(a[i]) * DPROD_W'(e[i]);
      end
   end

   // Sum exactly
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= DSUM_W'(prod_ff[0]) + DSUM_W'(prod_ff[1]) + DSUM_W'(prod_ff[2]);
      end
   end

   // Drop 16 fraction bits, rounding half away from zero
   always_comb begin
      mag = sum_ff[DSUM_W-1] ? DSUM_W'(-sum_ff) : DSUM_W'(sum_ff);
      rnd = (mag + DSUM_W'(32768)) >> FRAC_W;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff <= sum_ff[DSUM_W-1] ? -DRND_W'(rnd) : DRND_W'(rnd);
      end
   end

   assign dot = dot_ff;

endmodule
